### rtl/core/smv_pkg.sv
// ----------------------------------------------------------------------------
// smv_pkg
// Shared types and constants of the sparse matrix-vector product block.
// ----------------------------------------------------------------------------
package smv_pkg;

   // Field widths fixed by the stream format.
   localparam int OPCODE_WIDTH   = 2;
   localparam int INDEX_WIDTH    = 12;
   localparam int VALUE_WIDTH    = 32;
   localparam int SUM_WIDTH      = 64;
   localparam int CSR_DATA_WIDTH = 13;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int REQ_DATA_WIDTH = 48;
   localparam int RSP_DATA_WIDTH = 48;

   // Result queue sizing.
   localparam int RQ_DEPTH      = 8;
   localparam int RQ_PTR_WIDTH  = 3;
   localparam int RQ_CNT_WIDTH  = 4;

   // Item kinds carried in req_tuser.
   localparam logic [OPCODE_WIDTH-1:0] OP_LOAD  = 2'd0;
   localparam logic [OPCODE_WIDTH-1:0] OP_ENTRY = 2'd1;
   localparam logic [OPCODE_WIDTH-1:0] OP_EMPTY = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROW_COUNT   = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ACTIVE_ROWS = 1'b1;

   localparam logic [CSR_DATA_WIDTH-1:0] ROW_COUNT_RESET   = 13'd4096;
   localparam logic [CSR_DATA_WIDTH-1:0] ACTIVE_ROWS_RESET = 13'd4096;

   // Saturation limits of the Q16.16 result.
   localparam logic [VALUE_WIDTH-1:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [VALUE_WIDTH-1:0] Q_MIN = 32'h8000_0000;

   // One result waiting for transfer.
   typedef struct packed {
      logic                   saturated;
      logic [VALUE_WIDTH-1:0] row_result;
      logic [INDEX_WIDTH-1:0] row_index;
   } smv_result_type;

endpackage

### rtl/core/smv_ram.sv
// ----------------------------------------------------------------------------
// smv_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module smv_ram #(
   parameter int DATA_WIDTH = 32,
   parameter int DEPTH      = 4096
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [DATA_WIDTH-1:0]         wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [DATA_WIDTH-1:0]         rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/csr_sparse_matvec_active_rows.sv
// ----------------------------------------------------------------------------
// csr_sparse_matvec_active_rows
// Computes y = A * x for a matrix streamed row by row in compressed-row order.
// Load items (req_tuser = 0) write x into a vector memory of MAX_ROWS words.
// Entry items (req_tuser = 1) multiply their Q16.16 value by x[column] and
// add it into a 64-bit accumulator; the entry with req_tlast set, or an
// empty-row item (req_tuser = 2), ends the row and produces one result.
// Rows at or beyond active_rows return x at their own index unchanged.
// The block takes one item per clock cycle while it is not stalled. An item
// passes a memory read, a 32 x 32 multiply, the accumulate and the
// round/saturate logic; its result is written into the output queue from
// the stage 3 registers and can be transferred from there. Input stalls
// only while eight results are accepted but not yet transferred, which is
// the depth of the output queue. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module csr_sparse_matvec_active_rows
   import smv_pkg::*;
#(
   parameter int MAX_ROWS = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   // Input stream
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [11:0] position, [43:12] operand_value, [47:44] zero
   input  logic [REQ_DATA_WIDTH-1:0]   req_tdata,
   // [1:0] opcode
   input  logic [OPCODE_WIDTH-1:0]     req_tuser,
   input  logic                        req_tlast,
   // Result stream
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [11:0] row_index, [43:12] row_result, [47:44] zero
   output logic [RSP_DATA_WIDTH-1:0]   rsp_tdata,
   // [0] saturated
   output logic                        rsp_tuser,
   // Configuration writes
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]   csr_data
);

   localparam int ADDR_WIDTH = $clog2(MAX_ROWS);

   // Configuration registers.
   logic [CSR_DATA_WIDTH-1:0] row_count_ff;
   logic [CSR_DATA_WIDTH-1:0] active_rows_ff;

   // Accept-side control.
   logic [INDEX_WIDTH-1:0]  row_ff, row_in;
   logic [RQ_CNT_WIDTH-1:0] outstanding_ff, outstanding_in;
   logic                    req_xfer, rsp_xfer;
   logic                    is_load, is_entry, is_empty, emit, active, in_range, mac;
   logic [INDEX_WIDTH-1:0]  req_position;
   logic [VALUE_WIDTH-1:0]  req_value;
   logic [31:0]             pos_wide, row_wide, next_wide;
   logic [CSR_DATA_WIDTH-1:0] row_next;

   // Vector memory ports.
   logic                    vec_wr_en, vec_rd_en;
   logic [ADDR_WIDTH-1:0]   vec_wr_addr, vec_rd_addr;
   logic [VALUE_WIDTH-1:0]  vec_rd_data;

   // Pipeline stages.
   logic                    s1_mac_ff, s1_finish_ff, s1_active_ff;
   logic [INDEX_WIDTH-1:0]  s1_row_ff;
   logic [VALUE_WIDTH-1:0]  s1_operand_ff;
   logic                    s2_mac_ff, s2_finish_ff, s2_active_ff;
   logic [INDEX_WIDTH-1:0]  s2_row_ff;
   logic signed [SUM_WIDTH-1:0] s2_prod_ff;
   logic [VALUE_WIDTH-1:0]  s2_vec_ff;
   logic                    s3_finish_ff, s3_active_ff;
   logic [INDEX_WIDTH-1:0]  s3_row_ff;
   logic [SUM_WIDTH-1:0]    s3_sum_ff;
   logic [VALUE_WIDTH-1:0]  s3_vec_ff;
   logic [SUM_WIDTH-1:0]    sum_ff, sum_in, acc_sum;

   // Result formatting and queue.
   logic                    fits;
   smv_result_type          result;
   smv_result_type          rq_mem [RQ_DEPTH];
   logic [RQ_PTR_WIDTH-1:0] rq_wr_ptr_ff, rq_rd_ptr_ff;
   logic [RQ_CNT_WIDTH-1:0] rq_count_ff, rq_count_in;
   logic                    rq_push;
   smv_result_type          rq_head;

   // Configuration write port; every transfer is taken at once.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff   <= ROW_COUNT_RESET;
         active_rows_ff <= ACTIVE_ROWS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_ROW_COUNT:   row_count_ff   <= csr_data;
            REG_ACTIVE_ROWS: active_rows_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Decode the incoming item.
   assign req_position = req_tdata[INDEX_WIDTH-1:0];
   assign req_value    = req_tdata[INDEX_WIDTH+VALUE_WIDTH-1:INDEX_WIDTH];
   assign is_load      = (req_tuser == OP_LOAD);
   assign is_entry     = (req_tuser == OP_ENTRY);
   assign is_empty     = (req_tuser == OP_EMPTY);
   assign emit         = (is_entry && req_tlast) || is_empty;
   assign active       = ({1'b0, row_ff} < active_rows_ff);
   assign pos_wide     = 32'(req_position);
   assign row_wide     = 32'(row_ff);
   assign in_range     = (pos_wide < 32'(MAX_ROWS));
   assign mac          = is_entry && active && in_range;

   // An item is taken while the queue has room for every result in flight.
   assign req_tready = (outstanding_ff < RQ_CNT_WIDTH'(RQ_DEPTH));
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   // Row counter advances when a row ends and wraps at the row count or at MAX_ROWS.
   assign row_next  = {1'b0, row_ff} + 13'd1;
   assign next_wide = 32'(row_next);

   always_comb begin
      row_in = row_ff;
      if (req_xfer && emit) begin
         if ((row_next >= row_count_ff) || (next_wide >= 32'(MAX_ROWS))) begin
            row_in = '0;
         end else begin
            row_in = row_next[INDEX_WIDTH-1:0];
         end
      end
   end

   // Count of results accepted but not yet transferred.
   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_xfer && emit && !rsp_xfer) begin
         outstanding_in = outstanding_ff + 1'b1;
      end else if (!(req_xfer && emit) && rsp_xfer) begin
         outstanding_in = outstanding_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff         <= '0;
         outstanding_ff <= '0;
      end else begin
         row_ff         <= row_in;
         outstanding_ff <= outstanding_in;
      end
   end

   // Vector memory: loads write at accept; active entries read x[column], an
   // inactive row end reads x[row].
   assign vec_wr_en   = req_xfer && is_load && in_range;
   assign vec_wr_addr = pos_wide[ADDR_WIDTH-1:0];
   assign vec_rd_en   = req_xfer && (mac || (emit && !active));
   assign vec_rd_addr = mac ? pos_wide[ADDR_WIDTH-1:0] : row_wide[ADDR_WIDTH-1:0];

   smv_ram #(
      .DATA_WIDTH (VALUE_WIDTH),
      .DEPTH      (MAX_ROWS)
   ) u_vec_ram (
      .clock   (clock),
      .wr_en   (vec_wr_en),
      .wr_addr (vec_wr_addr),
      .wr_data (req_value),
      .rd_en   (vec_rd_en),
      .rd_addr (vec_rd_addr),
      .rd_data (vec_rd_data)
   );

   // Stage 1: memory read in progress.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_mac_ff    <= 1'b0;
         s1_finish_ff <= 1'b0;
      end else begin
         s1_mac_ff    <= req_xfer && mac;
         s1_finish_ff <= req_xfer && emit;
      end
   end

   always_ff @(posedge clock) begin
      s1_active_ff  <= active;
      s1_row_ff     <= row_ff;
      s1_operand_ff <= req_value;
   end

   // Stage 2: product of the entry value and the vector element.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_mac_ff    <= 1'b0;
         s2_finish_ff <= 1'b0;
      end else begin
         s2_mac_ff    <= s1_mac_ff;
         s2_finish_ff <= s1_finish_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_active_ff <= s1_active_ff;
      s2_row_ff    <= s1_row_ff;
      s2_vec_ff    <= vec_rd_data;
      s2_prod_ff   <= $signed(s1_operand_ff) * $signed(vec_rd_data);
   end

   // Stage 3: accumulate; a row end hands the sum on and clears the
   // accumulator.
   assign acc_sum = sum_ff + (s2_mac_ff ? SUM_WIDTH'(s2_prod_ff) : '0);
   assign sum_in  = s2_finish_ff ? '0 : acc_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         s3_finish_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         s3_finish_ff <= s2_finish_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_active_ff <= s2_active_ff;
      s3_row_ff    <= s2_row_ff;
      s3_vec_ff    <= s2_vec_ff;
      s3_sum_ff    <= acc_sum;
   end

   // Round toward minus infinity (drop 16 fraction bits) and saturate.
   assign fits = (&s3_sum_ff[SUM_WIDTH-1:47]) || !(|s3_sum_ff[SUM_WIDTH-1:47]);

   always_comb begin
      result.row_index = s3_row_ff;
      if (!s3_active_ff) begin
         result.row_result = s3_vec_ff;
         result.saturated  = 1'b0;
      end else if (fits) begin
         result.row_result = s3_sum_ff[47:16];
         result.saturated  = 1'b0;
      end else begin
         result.row_result = s3_sum_ff[SUM_WIDTH-1] ? Q_MIN : Q_MAX;
         result.saturated  = 1'b1;
      end
   end

   // Output queue of finished results.
   assign rq_push = s3_finish_ff;

   always_ff @(posedge clock) begin
      if (rq_push) begin
         rq_mem[rq_wr_ptr_ff] <= result;
      end
   end

   always_comb begin
      rq_count_in = rq_count_ff;
      if (rq_push && !rsp_xfer) begin
         rq_count_in = rq_count_ff + 1'b1;
      end else if (!rq_push && rsp_xfer) begin
         rq_count_in = rq_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ptr_ff <= '0;
         rq_rd_ptr_ff <= '0;
         rq_count_ff  <= '0;
      end else begin
         rq_count_ff <= rq_count_in;
         if (rq_push) begin
            rq_wr_ptr_ff <= rq_wr_ptr_ff + 1'b1;
         end
         if (rsp_xfer) begin
            rq_rd_ptr_ff <= rq_rd_ptr_ff + 1'b1;
         end
      end
   end

   assign rq_head    = rq_mem[rq_rd_ptr_ff];
   assign rsp_tvalid = (rq_count_ff != '0);
   assign rsp_tdata  = {4'b0, rq_head.row_result, rq_head.row_index};
   assign rsp_tuser  = rq_head.saturated;

   // Checks on the result bookkeeping.
   a_outstanding_bound: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= RQ_CNT_WIDTH'(RQ_DEPTH))
      else $error("more results outstanding than queue entries");

   a_queue_within_outstanding: assert property (@(posedge clock) disable iff (reset)
      rq_count_ff <= outstanding_ff)
      else $error("queue holds results that were never accepted");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rq_push |-> (rq_count_ff < RQ_CNT_WIDTH'(RQ_DEPTH)) || rsp_xfer)
      else $error("result pushed into a full queue");

   a_emit_counts: assert property (@(posedge clock) disable iff (reset)
      req_xfer && emit && !rsp_xfer |=> outstanding_ff == $past(outstanding_ff) + 1'b1)
      else $error("row end did not reserve a result slot");

endmodule

### tb/csr_sparse_matvec_active_rows_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csr_sparse_matvec_active_rows_tb
// Self-checking bench for the streamed sparse matrix-vector product. A short
// table of hand-picked items runs first. Random compressed-row traffic
// follows over several row-count and active-row settings. Every result is
// compared against its typed table result or else a predictor that keeps
// its own copy of the vector memory, the accumulator and the row counter.
// ----------------------------------------------------------------------------
module csr_sparse_matvec_active_rows_tb;
   import smv_pkg::*;

   localparam int VEC_DEPTH      = 4096;
   localparam int HOLD_LEN       = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int PHASE_ITEMS    = 200;

   // Opcode the block must drop without effect.
   localparam logic [OPCODE_WIDTH-1:0] OP_UNUSED = 2'd3;

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [OPCODE_WIDTH-1:0] op;
      logic [INDEX_WIDTH-1:0]  pos;
      logic [VALUE_WIDTH-1:0]  val;
      logic                    last;
      logic                    typed;
      smv_result_type          want;
   } stim_row_type;

   typedef struct packed {
      logic [CSR_DATA_WIDTH-1:0] rows;
      logic [CSR_DATA_WIDTH-1:0] active;
      idle_mode_type             mode;
   } phase_type;

   // Hand-picked items; the last two fields flag and give the typed result, if any.
   stim_row_type directed_rows [0:17] = '{
      '{OP_LOAD,   12'd0,     32'h0001_0000, 1'b0, 1'b0, '0},
      '{OP_LOAD,   12'd4095,  32'h7FFF_FFFF, 1'b0, 1'b0, '0},
      '{OP_LOAD,   12'd1,     32'h8000_0000, 1'b0, 1'b0, '0},
      '{OP_LOAD,   12'd2,     32'hFFFF_FFFF, 1'b0, 1'b0, '0},
      '{OP_ENTRY,  12'd0,     32'h0002_8000, 1'b1, 1'b1, '{1'b0, 32'h0002_8000, 12'd0}},
      '{OP_ENTRY,  12'd1,     32'h8000_0000, 1'b1, 1'b1, '{1'b1, Q_MAX, 12'd1}},
      '{OP_ENTRY,  12'd4095,  32'h8000_0000, 1'b1, 1'b1, '{1'b1, Q_MIN, 12'd2}},
      '{OP_EMPTY,  12'd4095,  32'hFFFF_FFFF, 1'b1, 1'b1, '{1'b0, 32'h0, 12'd3}},
      '{OP_UNUSED, 12'd0,     32'h1234_5678, 1'b1, 1'b0, '0},
      '{OP_ENTRY,  12'd2,     32'h0001_0000, 1'b0, 1'b0, '0},
      '{OP_ENTRY,  12'd0,     32'h0001_0000, 1'b0, 1'b0, '0},
      '{OP_ENTRY,  12'd2,     32'hFFFF_FFFF, 1'b1, 1'b0, '0},
      '{OP_ENTRY,  12'd2,     32'h0000_0001, 1'b1, 1'b0, '0},
      '{OP_LOAD,   12'h555,   32'h5555_5555, 1'b0, 1'b0, '0},
      '{OP_LOAD,   12'hAAA,   32'hAAAA_AAAA, 1'b0, 1'b0, '0},
      '{OP_ENTRY,  12'h555,   32'h0000_0003, 1'b0, 1'b0, '0},
      '{OP_ENTRY,  12'hAAA,   32'h7FFF_FFFF, 1'b1, 1'b0, '0},
      '{OP_EMPTY,  12'd0,     32'h0000_0000, 1'b0, 1'b1, '{1'b0, 32'h0, 12'd7}}
   };

   // Register settings and idling of the random phases.
   phase_type phases [0:7] = '{
      '{13'd4096, 13'd4096, IDLE_NONE},
      '{13'd1,    13'd0,    IDLE_SENDER},
      '{13'd7,    13'd3,    IDLE_RECEIVER},
      '{13'd16,   13'd20,   IDLE_BOTH},
      '{13'd4096, 13'd0,    IDLE_NONE},
      '{13'd5,    13'd5,    IDLE_SENDER},
      '{13'd100,  13'd40,   IDLE_RECEIVER},
      '{13'd4096, 13'd4096, IDLE_BOTH}
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   // [11:0] position, [43:12] operand_value, [47:44] zero
   logic [REQ_DATA_WIDTH-1:0]  req_tdata = '0;
   // [1:0] opcode
   logic [OPCODE_WIDTH-1:0]    req_tuser = OP_LOAD;
   logic                       req_tlast = 1'b0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   // [11:0] row_index, [43:12] row_result, [47:44] zero
   logic [RSP_DATA_WIDTH-1:0]  rsp_tdata;
   // [0] saturated
   logic                       rsp_tuser;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = REG_ROW_COUNT;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   // Predictor state.
   logic [VALUE_WIDTH-1:0]    vec_mem [0:VEC_DEPTH-1];
   bit                        vec_written [0:VEC_DEPTH-1];
   int                        written_cols [$];
   logic [SUM_WIDTH-1:0]      acc_sum = '0;
   logic [INDEX_WIDTH-1:0]    row_now = '0;
   logic [CSR_DATA_WIDTH-1:0] cfg_row_count = ROW_COUNT_RESET;
   logic [CSR_DATA_WIDTH-1:0] cfg_active_rows = ACTIVE_ROWS_RESET;
   smv_result_type            pending_rows [$];

   int errors = 0;
   int items_sent = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   csr_sparse_matvec_active_rows #(
      .MAX_ROWS(VEC_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Clock generation.
   initial begin
      forever #5 clock = ~clock;
   end

   // Ends a row: round toward minus infinity, saturate, advance the counter.
   function automatic smv_result_type close_row();
      smv_result_type            res;
      logic signed [SUM_WIDTH-1:0] q;
      logic [CSR_DATA_WIDTH-1:0] nxt;
      res.row_index = row_now;
      res.saturated = 1'b0;
      if (row_now < cfg_active_rows) begin
         q = $signed(acc_sum) >>> 16;
         if (q > 64'sd2147483647) begin
            res.row_result = Q_MAX;
            res.saturated  = 1'b1;
         end else if (q < -64'sd2147483648) begin
            res.row_result = Q_MIN;
            res.saturated  = 1'b1;
         end else begin
            res.row_result = q[VALUE_WIDTH-1:0];
         end
      end else begin
         res.row_result = vec_mem[row_now];
      end
      nxt = {1'b0, row_now} + 13'd1;
      if (nxt >= cfg_row_count || nxt >= VEC_DEPTH) begin
         nxt = '0;
      end
      row_now = nxt[INDEX_WIDTH-1:0];
      acc_sum = '0;
      return res;
   endfunction

   // Applies one accepted item; returns 1 when it ends a row.
   function automatic bit predict_item(input logic [OPCODE_WIDTH-1:0] op,
                                       input logic [INDEX_WIDTH-1:0] pos,
                                       input logic [VALUE_WIDTH-1:0] val,
                                       input logic last,
                                       output smv_result_type res);
      logic signed [SUM_WIDTH-1:0] mul_a;
      logic signed [SUM_WIDTH-1:0] mul_b;
      res = '0;
      case (op)
         OP_LOAD: begin
            vec_mem[pos] = val;
            if (!vec_written[pos]) begin
               vec_written[pos] = 1'b1;
               written_cols.push_back(int'(pos));
            end
            return 1'b0;
         end
         OP_ENTRY: begin
            if (row_now < cfg_active_rows) begin
               mul_a = $signed(val);
               mul_b = $signed(vec_mem[pos]);
               acc_sum = acc_sum + (mul_a * mul_b);
            end
            if (!last) begin
               return 1'b0;
            end
            res = close_row();
            return 1'b1;
         end
         OP_EMPTY: begin
            res = close_row();
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Random Q16.16 operand: full range, small values or extremes.
   function automatic logic [VALUE_WIDTH-1:0] rand_operand();
      case ($urandom_range(0, 2))
         0: return $urandom();
         1: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'hFFFF_FFFF;
               default: return 32'h0000_0000;
            endcase
         end
      endcase
   endfunction

   // Offers one item after a random gap and waits for its transfer.
   task automatic send_item(input logic [OPCODE_WIDTH-1:0] op,
                            input logic [INDEX_WIDTH-1:0] pos,
                            input logic [VALUE_WIDTH-1:0] val,
                            input logic last,
                            input logic typed,
                            input smv_result_type want);
      smv_result_type res;
      bit             ends_row;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, val, pos};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      ends_row = predict_item(op, pos, val, last, res);
      if (ends_row) begin
         pending_rows.push_back(typed ? want : res);
      end
      if (op != OP_UNUSED) begin
         items_sent++;
      end
   endtask

   // Stops offering and lets every expected result come out.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_rows.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write over the configuration channel.
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      if (idx == REG_ROW_COUNT) begin
         cfg_row_count = value;
      end else begin
         cfg_active_rows = value;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One random chunk of traffic: noise, vector loads or a whole row.
   task automatic make_row();
      int  kind;
      int  n;
      bit  live;
      kind = $urandom_range(0, 99);
      live = (row_now < cfg_active_rows);
      if (kind < 5) begin
         send_item(OP_UNUSED, 12'($urandom_range(0, 4095)), $urandom(),
                   1'($urandom_range(0, 1)), 1'b0, '0);
      end else if (kind < 25) begin
         n = $urandom_range(1, 4);
         repeat (n) begin
            send_item(OP_LOAD, 12'($urandom_range(0, 4095)), rand_operand(),
                      1'($urandom_range(0, 1)), 1'b0, '0);
         end
      end else begin
         // A copied row needs its own vector element written beforehand.
         if (!live && !vec_written[row_now]) begin
            send_item(OP_LOAD, row_now, rand_operand(), 1'b0, 1'b0, '0);
         end
         if (kind < 35) begin
            send_item(OP_EMPTY, 12'($urandom_range(0, 4095)), $urandom(),
                      1'($urandom_range(0, 1)), 1'b0, '0);
         end else begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
               send_item(OP_ENTRY,
                         live ? 12'(written_cols[$urandom_range(0, written_cols.size() - 1)])
                              : 12'($urandom_range(0, 4095)),
                         rand_operand(), (i == n - 1), 1'b0, '0);
            end
         end
      end
   endtask

   // Result side: random stalls, plus a long hold-off on request.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_LEN;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Compare each result transfer with the oldest expectation.
   always @(posedge clock) begin
      smv_result_type seen;
      smv_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.row_index  = rsp_tdata[11:0];
         seen.row_result = rsp_tdata[43:12];
         seen.saturated  = rsp_tuser;
         if (pending_rows.size() == 0) begin
            $error("result with no expectation waiting: row_index %0d", seen.row_index);
            errors++;
         end else begin
            want = pending_rows.pop_front();
            if (seen.row_index !== want.row_index) begin
               $error("row_index: expected %0d, got %0d", want.row_index, seen.row_index);
               errors++;
            end
            if (seen.row_result !== want.row_result) begin
               $error("row_result: expected %h, got %h", want.row_result, seen.row_result);
               errors++;
            end
            if (seen.saturated !== want.saturated) begin
               $error("saturated: expected %b, got %b", want.saturated, seen.saturated);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Main sequence.
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table under the reset settings, no idling.
      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].val,
                   directed_rows[i].last, directed_rows[i].typed, directed_rows[i].want);
      end
      drain();

      // Random phases, each under its own settings and idling.
      foreach (phases[p]) begin
         write_reg(REG_ROW_COUNT, phases[p].rows);
         write_reg(REG_ACTIVE_ROWS, phases[p].active);
         case (phases[p].mode)
            IDLE_NONE: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
               send_idle_pct  = 78;
               recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
               send_idle_pct  = 0;
               recv_stall_pct = 78;
            end
            default: begin
               send_idle_pct  = 32;
               recv_stall_pct = 32;
            end
         endcase
         // Fill the result queue once so the input has to stall.
         if (p == 0) begin
            hold_requests++;
         end
         items_sent = 0;
         while (items_sent < PHASE_ITEMS) begin
            make_row();
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (pending_rows.size() != 0) begin
         $error("%0d expected results never arrived", pending_rows.size());
         errors++;
      end
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
